// ===== design/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants for the breakpoint value mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

    localparam int MAX_POINTS = 7;
    localparam int POINT_REGS = 7;
    localparam int IDX_W      = 3;
    localparam int LAW_W      = 5;
    localparam int POINT_W    = 49;
    localparam int NORM_W     = 17;
    localparam int PHYS_W     = 32;
    localparam int KEY_W      = 33;
    localparam int NUM_W      = 49;
    localparam int DEN_W      = 32;
    localparam int QUOT_W     = 32;
    localparam int SUM_W      = 34;

    localparam logic [NORM_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [NORM_W-1:0] HALF_Q16 = 17'd32768;

    localparam logic [1:0] KIND_INVALID   = 2'd0;
    localparam logic [1:0] KIND_PIECEWISE = 2'd1;
    localparam logic [1:0] KIND_STEPPED   = 2'd2;
    localparam logic [1:0] KIND_TOGGLE    = 2'd3;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    localparam logic [IDX_W-1:0] REG_LAW_SETUP = 3'd0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // sideband that rides along with each transaction through the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] base;
        logic                    rnd;
        logic                    status;
    } side_t;

endpackage

`default_nettype wire

// ===== design/bvm_if.sv =====
// ----------------------------------------------------------------------------
// bvm_if
// Channel interfaces: request, response and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvm_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] value;
    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bvm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mapped;
    logic               status;
    modport source (output valid, output mapped, output status, input ready);
    modport sink   (input valid, input mapped, input status, output ready);
endinterface

interface bvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [48:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bvm_div.sv =====
// ----------------------------------------------------------------------------
// bvm_div
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [bvm_pkg::NUM_W-1:0] num,
    input  wire logic [bvm_pkg::DEN_W-1:0] den,
    input  wire bvm_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [bvm_pkg::QUOT_W-1:0]     quot,
    output bvm_pkg::side_t                 side_out
);
    import bvm_pkg::*;

    localparam int STAGES = QUOT_W;
    localparam int TW     = NUM_W + DEN_W + 1;

    logic              valid_reg [STAGES];
    logic [NUM_W-1:0]  rem_reg   [STAGES];
    logic [QUOT_W-1:0] q_reg     [STAGES];
    logic [DEN_W-1:0]  d_reg     [STAGES];
    side_t             side_reg  [STAGES];

    logic              valid_next [STAGES];
    logic [NUM_W-1:0]  rem_next   [STAGES];
    logic [QUOT_W-1:0] q_next     [STAGES];

    always_comb
    begin
        logic [NUM_W-1:0]  r_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W-1:0]  d_in;
        logic [TW-1:0]     trial;
        r_in  = '0;
        q_in  = '0;
        d_in  = '0;
        trial = '0;
        for (int j = 0; j < STAGES; j++)
        begin
            if (j == 0)
            begin
                r_in          = num;
                q_in          = '0;
                d_in          = den;
                valid_next[j] = in_valid;
            end
            else
            begin
                r_in          = rem_reg[j-1];
                q_in          = q_reg[j-1];
                d_in          = d_reg[j-1];
                valid_next[j] = valid_reg[j-1];
            end
            trial = TW'(r_in) - (TW'(d_in) << (STAGES - 1 - j));
            q_next[j] = q_in;
            if (!trial[TW-1])
            begin
                rem_next[j]              = trial[NUM_W-1:0];
                q_next[j][STAGES - 1 - j] = 1'b1;
            end
            else
            begin
                rem_next[j] = r_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < STAGES; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            for (int j = 0; j < STAGES; j++)
                valid_reg[j] <= valid_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                if (j == 0)
                begin
                    d_reg[j]    <= den;
                    side_reg[j] <= side_in;
                end
                else
                begin
                    d_reg[j]    <= d_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot      = q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== design/breakpoint_value_mapper.sv =====
// ----------------------------------------------------------------------------
// breakpoint_value_mapper
// Maps values through a breakpoint law (piecewise, stepped or toggle), forward or inverse.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  request   in    valid/ready   command, value
//  response  out   valid/ready   mapped, status
//  cfg       in    valid/ready   index, data (ready tied high)
//
//  One transaction per cycle while the response is not stalled; from accept to
//  response valid a transaction passes input, segment search, multiply, 32 divider
//  stages (one quotient bit each), add, round/output.
//  All stages move together; a stalled response freezes the whole pipe.
//  Reset clears config registers and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_value_mapper (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bvm_req_if.sink     request,
    bvm_rsp_if.source   response,
    bvm_cfg_if.sink     cfg
);
    import bvm_pkg::*;

    // configuration
    logic [LAW_W-1:0]   law_reg;
    logic [POINT_W-1:0] pt_reg [POINT_REGS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg <= '0;
            for (int i = 0; i < POINT_REGS; i++)
                pt_reg[i] <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_LAW_SETUP)
                law_reg <= cfg.data[LAW_W-1:0];
            else
                pt_reg[cfg.index - 3'd1] <= cfg.data;
        end
    end

    logic [1:0]               kind;
    logic [2:0]               cnt;
    logic [NORM_W-1:0]        norm [POINT_REGS];
    logic signed [PHYS_W-1:0] phys [POINT_REGS];
    logic                     law_ok;

    assign kind = law_reg[1:0];
    assign cnt  = law_reg[4:2];

    always_comb
    begin
        for (int i = 0; i < POINT_REGS; i++)
        begin
            norm[i] = pt_reg[i][48:32];
            phys[i] = pt_reg[i][31:0];
        end
    end

    always_comb
    begin
        law_ok = (kind != KIND_INVALID) && (cnt >= 3'd2) && (norm[0] == '0)
                 && (norm[cnt - 3'd1] == ONE_Q16);
        for (int i = 1; i < POINT_REGS; i++)
        begin
            if (i < int'(cnt))
            begin
                if (norm[i] <= norm[i-1] || phys[i] <= phys[i-1])
                    law_ok = 1'b0;
            end
        end
    end

    // pipeline control
    logic advance;
    logic out_valid_reg;

    assign advance       = !out_valid_reg || response.ready;
    assign request.ready = advance;

    // stage 1: input register
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic signed [31:0] s1_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= request.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg <= request.command;
            s1_val_reg <= request.value;
        end
    end

    // stage 2: clamp, segment search, operand select
    logic [DEN_W-1:0]  s2_a_next,   s2_a_reg;
    logic [DEN_W-1:0]  s2_b_next,   s2_b_reg;
    logic [DEN_W-1:0]  s2_den_next, s2_den_reg;
    side_t             s2_side_next, s2_side_reg;
    logic              s2_valid_reg;

    always_comb
    begin
        logic [NORM_W-1:0]        c_norm;
        logic signed [PHYS_W-1:0] lo, hi, c_phys;
        logic signed [KEY_W-1:0]  cv;
        logic signed [KEY_W-1:0]  key [POINT_REGS];
        logic signed [KEY_W-1:0]  oth [POINT_REGS];
        logic [2:0]               sel;
        logic signed [KEY_W-1:0]  x, dk, doth;
        logic signed [SUM_W-1:0]  two_v, mid2;

        if (s1_val_reg < 0)
            c_norm = '0;
        else if (s1_val_reg > $signed({15'b0, ONE_Q16}))
            c_norm = ONE_Q16;
        else
            c_norm = s1_val_reg[NORM_W-1:0];

        lo = phys[0];
        hi = phys[cnt - 3'd1];
        if (s1_val_reg < lo)
            c_phys = lo;
        else if (s1_val_reg > hi)
            c_phys = hi;
        else
            c_phys = s1_val_reg;

        cv = (s1_cmd_reg == CMD_INVERSE) ? {c_phys[31], c_phys} : {16'b0, c_norm};
        for (int i = 0; i < POINT_REGS; i++)
        begin
            if (s1_cmd_reg == CMD_INVERSE)
            begin
                key[i] = {phys[i][31], phys[i]};
                oth[i] = {16'b0, norm[i]};
            end
            else
            begin
                key[i] = {16'b0, norm[i]};
                oth[i] = {phys[i][31], phys[i]};
            end
        end

        // first segment whose upper key reaches the clamped value
        sel = 3'd1;
        for (int i = POINT_REGS - 1; i >= 1; i--)
        begin
            if (i < int'(cnt) && cv <= key[i])
                sel = 3'(i);
        end

        x    = cv - key[sel - 3'd1];
        dk   = key[sel] - key[sel - 3'd1];
        doth = oth[sel] - oth[sel - 3'd1];

        two_v = {s1_val_reg[31], s1_val_reg, 1'b0};
        mid2  = SUM_W'(phys[0]) + SUM_W'(phys[1]);

        s2_a_next              = doth[DEN_W-1:0];
        s2_b_next              = x[DEN_W-1:0];
        s2_den_next            = dk[DEN_W-1:0];
        s2_side_next.base      = SUM_W'(oth[sel - 3'd1]);
        s2_side_next.rnd       = (kind == KIND_STEPPED) && (s1_cmd_reg == CMD_FORWARD);
        s2_side_next.status    = STATUS_OK;

        if (!law_ok)
        begin
            s2_a_next           = '0;
            s2_den_next         = DEN_W'(1);
            s2_side_next.base   = '0;
            s2_side_next.rnd    = 1'b0;
            s2_side_next.status = STATUS_INVALID;
        end
        else if (kind == KIND_TOGGLE)
        begin
            s2_a_next        = '0;
            s2_den_next      = DEN_W'(1);
            s2_side_next.rnd = 1'b0;
            if (s1_cmd_reg == CMD_FORWARD)
                s2_side_next.base = (s1_val_reg < $signed({15'b0, HALF_Q16}))
                                    ? SUM_W'(phys[0]) : SUM_W'(phys[1]);
            else
                s2_side_next.base = (two_v < mid2) ? '0 : SUM_W'(ONE_Q16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_next;
            s2_den_reg  <= s2_den_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // stage 3: multiply
    logic             s3_valid_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic [DEN_W-1:0] s3_den_reg;
    side_t            s3_side_reg;
    logic [2*DEN_W-1:0] prod;

    assign prod = s2_a_reg * s2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_num_reg  <= prod[NUM_W-1:0];
            s3_den_reg  <= s2_den_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // divider
    logic              dv_valid;
    logic [QUOT_W-1:0] dv_quot;
    side_t             dv_side;

    bvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den       (s3_den_reg),
        .side_in   (s3_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // add stage
    logic                    sa_valid_reg;
    logic signed [SUM_W-1:0] sa_sum_reg;
    logic                    sa_rnd_reg;
    logic                    sa_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_valid_reg <= 1'b0;
        else if (advance)
            sa_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sa_sum_reg    <= dv_side.base + $signed({2'b0, dv_quot});
            sa_rnd_reg    <= dv_side.rnd;
            sa_status_reg <= dv_side.status;
        end
    end

    // output stage: optional rounding to a whole unit
    logic [31:0] mapped_next;
    logic [31:0] mapped_reg;
    logic        status_reg;
    logic        rnd_out_reg;

    always_comb
    begin
        logic [SUM_W:0] mag, t, qv;
        mag = '0;
        t   = '0;
        qv  = '0;
        mapped_next = sa_sum_reg[31:0];
        if (sa_rnd_reg)
        begin
            if (!sa_sum_reg[SUM_W-1])
            begin
                t  = {1'b0, sa_sum_reg} + (SUM_W+1)'(HALF_Q16);
                qv = {t[SUM_W:16], 16'b0};
                if (qv > (SUM_W+1)'(32'h7FFF_FFFF))
                    mapped_next = 32'h7FFF_FFFF;
                else
                    mapped_next = qv[31:0];
            end
            else
            begin
                mag = (SUM_W+1)'(0) - {sa_sum_reg[SUM_W-1], sa_sum_reg};
                t   = mag + (SUM_W+1)'(HALF_Q16);
                qv  = {t[SUM_W:16], 16'b0};
                mapped_next = 32'(0) - qv[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= sa_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mapped_reg  <= mapped_next;
            status_reg  <= sa_status_reg;
            rnd_out_reg <= sa_rnd_reg;
        end
    end

    assign response.valid  = out_valid_reg;
    assign response.mapped = mapped_reg;
    assign response.status = status_reg;

    // checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> mapped_reg == '0)
        else $error("error result with nonzero value");

    a_step_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rnd_out_reg |->
            mapped_reg[15:0] == 16'h0 || mapped_reg == 32'h7FFF_FFFF)
        else $error("stepped result not a whole unit");

    a_bad_law: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && !law_ok |=> s2_valid_reg && s2_side_reg.status)
        else $error("invalid law not flagged");

endmodule

`default_nettype wire
